### src/hstr_pkg.sv
// Shared types and constants for the half-space triangle rasterizer.
package hstr_pkg;

  localparam int COORD_W  = 12;
  localparam int CRD1_W   = COORD_W + 1;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int EDGE_W   = 2 * COORD_W + 3;
  localparam int COLOR_W  = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] vertex_a_x;
    logic signed [COORD_W-1:0] vertex_a_y;
    logic signed [COORD_W-1:0] vertex_b_x;
    logic signed [COORD_W-1:0] vertex_b_y;
    logic signed [COORD_W-1:0] vertex_c_x;
    logic signed [COORD_W-1:0] vertex_c_y;
    logic [COLOR_W-1:0]        fill_color;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      covered;
    logic                      last;
  } out_item_t;

endpackage

### src/half_space_triangle_rasterizer.sv
// Half-space triangle rasterizer: triangle setup on load, one box pixel per tick.
// A tick's result is registered: it passes the input register, then the result register.
// Throughput: one item per cycle (load or tick) while out_stall does not hold the result;
// set by the single edge-update stage between the input register and the result register.
// Loads give no result; a load takes effect before the tick that follows it.
// Reset (rst_n low, synchronous) empties both registers and leaves no triangle active.
module half_space_triangle_rasterizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hstr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hstr_pkg::out_item_t out_data
);
  import hstr_pkg::*;

  // input register
  logic     in_vld_r;
  in_item_t in_data_r;

  // result register
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_data_r, out_data_nxt;

  // triangle state; edge values are stored unscaled, in whole pixel units, with the
  // top-left fill correction kept as a separate bias bit
  edge_t  row_r [3];
  edge_t  row_nxt [3];
  edge_t  col_r [3];
  edge_t  col_nxt [3];
  diff_t  dx_r [3];
  diff_t  dx_nxt [3];
  diff_t  dy_r [3];
  diff_t  dy_nxt [3];
  logic [2:0] bias_r, bias_nxt;
  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  coord_t box_left_r, box_left_nxt;
  coord_t box_right_r, box_right_nxt;
  coord_t box_bottom_r, box_bottom_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic busy_r, busy_nxt;

  logic proc;
  logic fin;

  function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  assign proc     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !proc;

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_comb begin
    coord_t vx [3];
    coord_t vy [3];
    coord_t left, right, top, bottom;
    diff_t  ddx, ddy, ox, oy;
    logic signed [PROD_W-1:0] p_col, p_row;
    logic signed [CRD1_W-1:0] x_inc, y_inc;
    logic cov, wrap;

    row_nxt        = row_r;
    col_nxt        = col_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    bias_nxt       = bias_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    box_left_nxt   = box_left_r;
    box_right_nxt  = box_right_r;
    box_bottom_nxt = box_bottom_r;
    color_nxt      = color_r;
    busy_nxt       = busy_r;
    out_data_nxt   = out_data_r;
    out_vld_nxt    = out_vld_r && out_stall;
    ddx            = '0;
    ddy            = '0;
    ox             = '0;
    oy             = '0;
    p_col          = '0;
    p_row          = '0;

    vx[0] = in_data_r.vertex_a_x;
    vy[0] = in_data_r.vertex_a_y;
    vx[1] = in_data_r.vertex_b_x;
    vy[1] = in_data_r.vertex_b_y;
    vx[2] = in_data_r.vertex_c_x;
    vy[2] = in_data_r.vertex_c_y;
    left   = min3(vx[0], vx[1], vx[2]);
    right  = max3(vx[0], vx[1], vx[2]);
    top    = min3(vy[0], vy[1], vy[2]);
    bottom = max3(vy[0], vy[1], vy[2]);

    x_inc = CRD1_W'(cur_x_r) + CRD1_W'(1);
    y_inc = CRD1_W'(cur_y_r) + CRD1_W'(1);
    wrap  = (x_inc >= CRD1_W'(box_right_r));
    fin   = (x_inc == CRD1_W'(box_right_r)) && (y_inc == CRD1_W'(box_bottom_r));
    cov   = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cov = cov && ((col_r[i] > 0) || ((col_r[i] == 0) && bias_r[i]));
    end

    if (proc) begin
      if (in_data_r.operation == OP_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          ddx   = DIFF_W'(vx[i]) - DIFF_W'(vx[(i + 1) % 3]);
          ddy   = DIFF_W'(vy[i]) - DIFF_W'(vy[(i + 1) % 3]);
          ox    = DIFF_W'(vx[i]) - DIFF_W'(left);
          oy    = DIFF_W'(vy[i]) - DIFF_W'(top);
          p_col = ddy * ox;
          p_row = ddx * oy;
          row_nxt[i]  = EDGE_W'(p_col) - EDGE_W'(p_row);
          col_nxt[i]  = EDGE_W'(p_col) - EDGE_W'(p_row);
          dx_nxt[i]   = ddx;
          dy_nxt[i]   = ddy;
          bias_nxt[i] = (ddy < 0) || ((ddy == 0) && (ddx > 0));
        end
        cur_x_nxt      = left;
        cur_y_nxt      = top;
        box_left_nxt   = left;
        box_right_nxt  = right;
        box_bottom_nxt = bottom;
        color_nxt      = in_data_r.fill_color;
        busy_nxt       = (left < right) && (top < bottom);
      end else if (busy_r) begin
        out_vld_nxt              = 1'b1;
        out_data_nxt.pixel_x     = cur_x_r;
        out_data_nxt.pixel_y     = cur_y_r;
        out_data_nxt.pixel_color = color_r;
        out_data_nxt.covered     = cov;
        out_data_nxt.last        = fin;
        if (wrap) begin
          // end of row: step the row accumulators down one line
          cur_x_nxt = box_left_r;
          cur_y_nxt = COORD_W'(y_inc);
          for (int i = 0; i < 3; i++) begin
            row_nxt[i] = row_r[i] + EDGE_W'(dx_r[i]);
            col_nxt[i] = row_r[i] + EDGE_W'(dx_r[i]);
          end
          if (y_inc >= CRD1_W'(box_bottom_r)) begin
            busy_nxt = 1'b0;
          end
        end else begin
          cur_x_nxt = COORD_W'(x_inc);
          for (int i = 0; i < 3; i++) begin
            col_nxt[i] = col_r[i] - EDGE_W'(dy_r[i]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      busy_r    <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
      busy_r    <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data;
    end
    out_data_r   <= out_data_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    bias_r       <= bias_nxt;
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    box_left_r   <= box_left_nxt;
    box_right_r  <= box_right_nxt;
    box_bottom_r <= box_bottom_nxt;
    color_r      <= color_nxt;
  end

  // a triangle only goes inactive through an item that was processed
  a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(proc))
    else $error("busy dropped without a processed item");

  // the final pixel of the box retires the triangle
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (in_data_r.operation == OP_TICK) && busy_r && fin) |=> !busy_r)
    else $error("triangle still active after its last pixel");

  // scan position stays within the box's x range and above its bottom edge while active
  a_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_x_r >= box_left_r) && (cur_x_r < box_right_r) &&
               (cur_y_r < box_bottom_r))
    else $error("scan position outside bounding box");

  // a new result appears only from a processed tick
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(proc && busy_r && (in_data_r.operation == OP_TICK)))
    else $error("result without a processed tick");

endmodule
